[sv/windowed_sample_statistics_defines.svh]
// ----------------------------------------------------------------------------
// Windowed sample statistics assertion macros
// Shared assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_SAMPLE_STATISTICS_DEFINES_SVH
`define WINDOWED_SAMPLE_STATISTICS_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define WSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define WSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/wss_pkg.sv]
// ----------------------------------------------------------------------------
// Windowed sample statistics package
// Types and constants shared by the statistics block.
// ----------------------------------------------------------------------------
package wss_pkg;

    localparam int SAMPLE_W = 12;
    localparam int CFG_W    = 32;
    localparam int CFG_IW   = 2;
    localparam int AVG_W    = 16;

    localparam logic [CFG_IW-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_INTERVAL     = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_READ_MODE    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAND_ADDR,
        ST_CAND_LAT,
        ST_SWEEP,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } wss_state_t;

endpackage

[sv/wss_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wss_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/windowed_sample_statistics.sv]
// ----------------------------------------------------------------------------
// Windowed sample statistics
// Sliding-window median, min, max and average over captured ADC samples.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat (in_valid/in_stall) is one poll: timestamp and two
//   readings. A poll captures when the elapsed time since the last capture
//   reaches sample_interval_ms. Exactly one output beat follows each poll.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
//   written only while the block is idle.
//   A poll before the window is full shows its result beat in the cycle after
//   acceptance. Once full, the rank search steps through n candidates, each
//   through CAND_ADDR, CAND_LAT, a SWEEP over the window and EVAL (ends
//   early once both medians are found), followed by a bit-serial divide.
//   The search is serial because each sample RAM has a single read port.
//   One poll is in flight at a time: in_stall stays high from acceptance until
//   the result beat is taken. A stalled result holds its value.
//   Reset clears position, fill flag, last capture time and the registers to
//   their defaults; sample memories are not cleared.
// ----------------------------------------------------------------------------
module windowed_sample_statistics import wss_pkg::*; #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         now_ms,
    input  logic [SAMPLE_W-1:0] adc_raw,
    input  logic [SAMPLE_W-1:0] adc_millivolts,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                ready_res,
    output logic                captured,
    output logic [SAMPLE_W-1:0] median_value,
    output logic [SAMPLE_W-1:0] raw_median_value,
    output logic [AVG_W-1:0]    average_x16,
    output logic [SAMPLE_W-1:0] min_value,
    output logic [SAMPLE_W-1:0] max_value
);

    localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int NW  = $clog2(WINDOW_DEPTH + 1);
    localparam int CW  = (NW > 6) ? NW : 6;
    localparam int SW  = $clog2(WINDOW_DEPTH * 4095 + 1);
    localparam int DW  = SW + 4;
    localparam int DCW = $clog2(DW);

    wss_state_t state_reg, state_next;

    logic [5:0]          sample_count_reg;
    logic [31:0]         interval_reg;
    logic                read_mode_reg;
    logic [AW-1:0]       pos_reg;
    logic                full_reg;
    logic [31:0]         last_reg;

    logic [AW-1:0]       i_reg, j_reg;
    logic [SAMPLE_W-1:0] cand_s_reg, cand_r_reg;
    logic [NW-1:0]       lt_s_reg, le_s_reg, lt_r_reg, le_r_reg;
    logic                found_s_reg, found_r_reg;
    logic [SW-1:0]       sum_reg;
    logic [NW-1:0]       rem_reg;
    logic [DW-1:0]       quot_reg;
    logic [DCW-1:0]      dcnt_reg;

    logic                cap_reg;
    logic [SAMPLE_W-1:0] med_s_reg, med_r_reg, lo_reg, hi_reg;
    logic [AVG_W-1:0]    avg_reg;

    logic [NW-1:0]       n_len;
    logic [CW-1:0]       sc_ext;
    logic                in_acc;
    logic                cap;
    logic [NW:0]         pos_inc;
    logic                wrap;
    logic                full_now;
    logic [AW-1:0]       rd_addr;
    logic [SAMPLE_W-1:0] s_rdata, r_rdata, s_wdata;
    logic [NW-1:0]       k_rank;
    logic                hit_s, hit_r, done_s, done_r, last_cand;
    logic [NW:0]         rem_sh;
    logic                sub_ok;
    logic [DW-1:0]       quot_next;

    // Active window length, clamped to 1..WINDOW_DEPTH
    assign sc_ext = CW'(sample_count_reg);
    always_comb
    begin
        if (sc_ext == '0)
        begin
            n_len = NW'(1);
        end
        else if (sc_ext > CW'(WINDOW_DEPTH))
        begin
            n_len = NW'(WINDOW_DEPTH);
        end
        else
        begin
            n_len = NW'(sc_ext);
        end
    end

    assign in_acc   = in_valid && !in_stall;
    assign cap      = (now_ms - last_reg) >= interval_reg;
    assign pos_inc  = (NW + 1)'(pos_reg) + (NW + 1)'(1);
    assign wrap     = pos_inc >= {1'b0, n_len};
    assign full_now = full_reg || (cap && wrap);
    assign s_wdata  = read_mode_reg ? adc_millivolts : adc_raw;

    assign k_rank    = n_len >> 1;
    assign hit_s     = (lt_s_reg <= k_rank) && (k_rank < le_s_reg);
    assign hit_r     = (lt_r_reg <= k_rank) && (k_rank < le_r_reg);
    assign done_s    = found_s_reg || hit_s;
    assign done_r    = found_r_reg || hit_r;
    assign last_cand = (NW'(i_reg) == n_len - NW'(1));

    // Restoring divide step: one quotient bit per cycle
    assign rem_sh    = {rem_reg, quot_reg[DW-1]};
    assign sub_ok    = rem_sh >= {1'b0, n_len};
    assign quot_next = {quot_reg[DW-2:0], sub_ok};

    wss_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) sample_ram (
        .clk   (clk),
        .we    (in_acc && cap),
        .waddr (pos_reg),
        .wdata (s_wdata),
        .raddr (rd_addr),
        .rdata (s_rdata)
    );

    wss_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) raw_ram (
        .clk   (clk),
        .we    (in_acc && cap),
        .waddr (pos_reg),
        .wdata (adc_raw),
        .raddr (rd_addr),
        .rdata (r_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = full_now ? ST_CAND_ADDR : ST_OUT;
                end
            end
            ST_CAND_ADDR: state_next = ST_CAND_LAT;
            ST_CAND_LAT:  state_next = ST_SWEEP;
            ST_SWEEP:
            begin
                if (NW'(j_reg) == n_len - NW'(1))
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ((done_s && done_r) || last_cand) ? ST_DIV : ST_CAND_ADDR;
            end
            ST_DIV:
            begin
                if (dcnt_reg == '0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        rd_addr   = '0;
        case (state_reg)
            ST_IDLE:      in_stall = 1'b0;
            ST_CAND_ADDR: rd_addr = i_reg;
            ST_CAND_LAT:  rd_addr = '0;
            ST_SWEEP:     rd_addr = j_reg + AW'(1);
            ST_OUT:       out_valid = 1'b1;
            default:      rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_count_reg <= 6'd32;
            interval_reg     <= '0;
            read_mode_reg    <= 1'b0;
            pos_reg          <= '0;
            full_reg         <= 1'b0;
            last_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data[5:0];
                    CFG_INTERVAL:     interval_reg     <= cfg_data;
                    CFG_READ_MODE:    read_mode_reg    <= cfg_data[0];
                    default:          read_mode_reg    <= read_mode_reg;
                endcase
            end
            if (in_acc && cap)
            begin
                last_reg <= now_ms;
                full_reg <= full_now;
                pos_reg  <= wrap ? '0 : AW'(pos_inc);
            end
        end
    end

    // Search, statistics and divide datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cap_reg     <= cap;
                    i_reg       <= '0;
                    found_s_reg <= 1'b0;
                    found_r_reg <= 1'b0;
                    med_s_reg   <= '0;
                    med_r_reg   <= '0;
                    avg_reg     <= '0;
                    lo_reg      <= '0;
                    hi_reg      <= '0;
                end
            end
            ST_CAND_LAT:
            begin
                cand_s_reg <= s_rdata;
                cand_r_reg <= r_rdata;
                lt_s_reg   <= '0;
                le_s_reg   <= '0;
                lt_r_reg   <= '0;
                le_r_reg   <= '0;
                j_reg      <= '0;
            end
            ST_SWEEP:
            begin
                lt_s_reg <= lt_s_reg + NW'(s_rdata <  cand_s_reg);
                le_s_reg <= le_s_reg + NW'(s_rdata <= cand_s_reg);
                lt_r_reg <= lt_r_reg + NW'(r_rdata <  cand_r_reg);
                le_r_reg <= le_r_reg + NW'(r_rdata <= cand_r_reg);
                // First candidate pass also gathers sum, min and max
                if (i_reg == '0)
                begin
                    if (j_reg == '0)
                    begin
                        sum_reg <= SW'(s_rdata);
                        lo_reg  <= s_rdata;
                        hi_reg  <= s_rdata;
                    end
                    else
                    begin
                        sum_reg <= sum_reg + SW'(s_rdata);
                        if (s_rdata < lo_reg)
                        begin
                            lo_reg <= s_rdata;
                        end
                        if (s_rdata > hi_reg)
                        begin
                            hi_reg <= s_rdata;
                        end
                    end
                end
                j_reg <= j_reg + AW'(1);
            end
            ST_EVAL:
            begin
                if (!found_s_reg && hit_s)
                begin
                    med_s_reg <= cand_s_reg;
                end
                if (!found_r_reg && hit_r)
                begin
                    med_r_reg <= cand_r_reg;
                end
                found_s_reg <= done_s;
                found_r_reg <= done_r;
                i_reg       <= i_reg + AW'(1);
                rem_reg     <= '0;
                quot_reg    <= {sum_reg, 4'b0000};
                dcnt_reg    <= DCW'(DW - 1);
            end
            ST_DIV:
            begin
                rem_reg  <= sub_ok ? NW'(rem_sh - {1'b0, n_len}) : NW'(rem_sh);
                quot_reg <= quot_next;
                dcnt_reg <= dcnt_reg - DCW'(1);
                if (dcnt_reg == '0)
                begin
                    avg_reg <= quot_next[AVG_W-1:0];
                end
            end
            default:
            begin
                cap_reg <= cap_reg;
            end
        endcase
    end

    assign ready_res        = full_reg;
    assign captured         = cap_reg;
    assign median_value     = med_s_reg;
    assign raw_median_value = med_r_reg;
    assign average_x16      = avg_reg;
    assign min_value        = lo_reg;
    assign max_value        = hi_reg;

endmodule

[sv/wss_checker.sv]
// ----------------------------------------------------------------------------
// Windowed sample statistics checker
// Port-level properties of the statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`include "windowed_sample_statistics_defines.svh"

module wss_props import wss_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic                ready_res,
    input logic [SAMPLE_W-1:0] median_value,
    input logic [AVG_W-1:0]    average_x16,
    input logic [SAMPLE_W-1:0] min_value,
    input logic [SAMPLE_W-1:0] max_value
);

    `WSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(median_value) && $stable(average_x16),
        "stalled result beat changed")
    `WSS_ASSERT_NOW(a_one_in_flight, clk, rst_n, out_valid, in_stall,
        "input taken while a result waits")
    `WSS_ASSERT_NOW(a_zero_until_full, clk, rst_n, out_valid && !ready_res,
        median_value == '0 && average_x16 == '0 && min_value == '0 && max_value == '0,
        "statistics nonzero before window full")
    `WSS_ASSERT_NOW(a_order, clk, rst_n, out_valid && ready_res,
        min_value <= median_value && median_value <= max_value
        && (AVG_W'(min_value) << 4) <= average_x16
        && average_x16 <= (AVG_W'(max_value) << 4),
        "statistics out of order")

endmodule

bind windowed_sample_statistics wss_props checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ready_res    (ready_res),
    .median_value (median_value),
    .average_x16  (average_x16),
    .min_value    (min_value),
    .max_value    (max_value)
);

[tb/wss_checker.sv]
// ----------------------------------------------------------------------------
// Windowed sample statistics checker
// Watches the poll and result channels, keeps its own copy of the window and
// registers, predicts one result per accepted poll and compares field by field.
// ----------------------------------------------------------------------------
module wss_checker import wss_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [31:0]         now_ms,
    input  logic [SAMPLE_W-1:0] adc_raw,
    input  logic [SAMPLE_W-1:0] adc_millivolts,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                ready_res,
    input  logic                captured,
    input  logic [SAMPLE_W-1:0] median_value,
    input  logic [SAMPLE_W-1:0] raw_median_value,
    input  logic [AVG_W-1:0]    average_x16,
    input  logic [SAMPLE_W-1:0] min_value,
    input  logic [SAMPLE_W-1:0] max_value,
    output int                  fail_count,
    output int                  pending_stats
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;

    typedef struct packed {
        logic                full;
        logic                cap;
        logic [SAMPLE_W-1:0] med;
        logic [SAMPLE_W-1:0] rmed;
        logic [AVG_W-1:0]    avg;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
    } stats_t;

    stats_t              stats_q[$];
    logic [SAMPLE_W-1:0] sample_win[DEPTH];
    logic [SAMPLE_W-1:0] raw_win[DEPTH];
    int unsigned         wpos;
    logic                full_flag;
    logic [31:0]         last_cap;
    logic [5:0]          win_len_reg;
    logic [31:0]         interval_reg;
    logic                mv_mode;

    assign pending_stats = stats_q.size();

    function automatic logic [SAMPLE_W-1:0] rank_mid(input logic [SAMPLE_W-1:0] v[DEPTH],
                                                     input int n);
        logic [SAMPLE_W-1:0] s[$];
        for (int i = 0; i < n; i++)
            s.push_back(v[i]);
        s.sort();
        return s[n/2];
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic predict_poll(input logic [31:0] t, input logic [SAMPLE_W-1:0] raw,
                                input logic [SAMPLE_W-1:0] mv);
        stats_t      r;
        int          n;
        int unsigned sum;
        r = '0;
        n = (win_len_reg < 1) ? 1 : (win_len_reg > DEPTH) ? DEPTH : int'(win_len_reg);
        if (t - last_cap >= interval_reg)
        begin
            r.cap = 1'b1;
            last_cap = t;
            sample_win[wpos] = mv_mode ? mv : raw;
            raw_win[wpos] = raw;
            wpos++;
            if (wpos >= n)
            begin
                wpos = 0;
                full_flag = 1'b1;
            end
        end
        if (full_flag)
        begin
            sum = 0;
            r.lo = sample_win[0];
            r.hi = sample_win[0];
            for (int i = 0; i < n; i++)
            begin
                sum += 32'(sample_win[i]);
                if (sample_win[i] < r.lo) r.lo = sample_win[i];
                if (sample_win[i] > r.hi) r.hi = sample_win[i];
            end
            r.avg = AVG_W'((sum * 16) / n);
            r.med = rank_mid(sample_win, n);
            r.rmed = rank_mid(raw_win, n);
        end
        r.full = full_flag;
        stats_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stats_t w;
        if (!rst_n)
        begin
            wpos = 0;
            full_flag = 1'b0;
            last_cap = '0;
            win_len_reg = 6'd32;
            interval_reg = '0;
            mv_mode = 1'b0;
            fail_count = 0;
            stats_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SAMPLE_COUNT) win_len_reg = cfg_data[5:0];
                else if (cfg_index == CFG_INTERVAL) interval_reg = cfg_data;
                else if (cfg_index == CFG_READ_MODE) mv_mode = cfg_data[0];
            end
            if (out_valid && !out_stall)
            begin
                if (stats_q.size() == 0)
                begin
                    report("unexpected result beat", 1, 0);
                end
                else
                begin
                    w = stats_q.pop_front();
                    if (ready_res !== w.full)
                        report("ready_res", int'(ready_res), int'(w.full));
                    if (captured !== w.cap)
                        report("captured", int'(captured), int'(w.cap));
                    if (median_value !== w.med)
                        report("median_value", int'(median_value), int'(w.med));
                    if (raw_median_value !== w.rmed)
                        report("raw_median_value", int'(raw_median_value), int'(w.rmed));
                    if (average_x16 !== w.avg)
                        report("average_x16", int'(average_x16), int'(w.avg));
                    if (min_value !== w.lo)
                        report("min_value", int'(min_value), int'(w.lo));
                    if (max_value !== w.hi)
                        report("max_value", int'(max_value), int'(w.hi));
                end
            end
            if (in_valid && !in_stall)
                predict_poll(now_ms, adc_raw, adc_millivolts);
        end
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Windowed sample statistics testbench
// Drives timed polls through several window lengths, intervals and read modes
// with random gaps and stalls; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_top import wss_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [31:0]         now_ms;
    logic [SAMPLE_W-1:0] adc_raw;
    logic [SAMPLE_W-1:0] adc_millivolts;
    logic                out_valid;
    logic                out_stall;
    logic                ready_res;
    logic                captured;
    logic [SAMPLE_W-1:0] median_value;
    logic [SAMPLE_W-1:0] raw_median_value;
    logic [AVG_W-1:0]    average_x16;
    logic [SAMPLE_W-1:0] min_value;
    logic [SAMPLE_W-1:0] max_value;
    int                  fail_count;
    int                  pending_stats;
    int                  idle_cycles;
    logic [31:0]         clock_ms;
    int unsigned         cur_interval;
    bit                  stall_free;

    windowed_sample_statistics dut (.*);

    wss_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hold each result beat for a randomly drawn stall (none in a stall-free phase), then take it
    initial
    begin
        int hold;
        out_stall = 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_stall)
            begin
                hold = stall_free ? 0 : $urandom_range(0, 7);
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_INTERVAL)
            cur_interval = val;
    endtask

    task automatic send_poll(input logic [31:0] t, input logic [SAMPLE_W-1:0] raw,
                             input logic [SAMPLE_W-1:0] mv);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 7);
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        now_ms <= t;
        adc_raw <= raw;
        adc_millivolts <= mv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        in_valid <= 1'b0;
    endtask

    // random poll: timestamp step is usually around the interval
    task automatic random_poll();
        logic [31:0] step;
        case ($urandom_range(0, 5))
            0: step = 0;
            1: step = $urandom();
            2: step = cur_interval - 1;
            default: step = cur_interval + $urandom_range(0, 3);
        endcase
        clock_ms = clock_ms + step;
        send_poll(clock_ms, SAMPLE_W'($urandom_range(0, 4095)),
                  SAMPLE_W'($urandom_range(0, 4095)));
    endtask

    task automatic drain();
        while (pending_stats != 0) @(posedge clk);
        repeat (1300) @(posedge clk);
    endtask

    // every entry is written by the first full window, so any length is safe after it
    task automatic phase(input logic [5:0] len, input logic [31:0] ivl,
                         input bit mode, input int polls);
        drain();
        write_reg(CFG_SAMPLE_COUNT, CFG_W'(len));
        write_reg(CFG_INTERVAL, ivl);
        write_reg(CFG_READ_MODE, CFG_W'(mode));
        stall_free = ($urandom_range(0, 3) == 0);
        repeat (polls) random_poll();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        now_ms = '0;
        adc_raw = '0;
        adc_millivolts = '0;
        clock_ms = '0;
        cur_interval = 0;
        stall_free = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill a full window with extremes, raw mode, interval zero
        for (int i = 0; i < 32; i++)
            send_poll(i, (i % 2) ? 12'hFFF : 12'h000, (i % 3) ? 12'hFFF : 12'h555);
        send_poll(32'hFFFF_FFFF, 12'hFFF, 12'h000);
        send_poll(32'h0000_0000, 12'hAAA, 12'h555);
        // directed: oversized length, then shrink past the position, then zero
        phase(6'd63, 32'd0, 1'b1, 8);
        phase(6'd3, 32'd0, 1'b1, 4);
        phase(6'd0, 32'd10, 1'b0, 6);
        // directed: maximum interval and wrapping timestamps
        drain();
        write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_FFF0;
        send_poll(clock_ms, 12'h123, 12'hFFF);
        send_poll(clock_ms + 32'hFFFF_FFFE, 12'h456, 12'h000);
        send_poll(clock_ms - 1, 12'h789, 12'h800);

        // random phases over lengths from zero to oversized
        phase(6'd1, 32'd0, 1'b0, 40);
        phase(6'd1, 32'd5, 1'b1, 40);
        phase(6'd1, 32'd0, 1'b1, 30);
        for (int p = 0; p < 12; p++)
            phase(6'($urandom_range(0, 40)),
                  $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 50),
                  1'($urandom_range(0, 1)), 31);
        drain();
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/wss_pkg.sv
sv/wss_ram.sv
sv/windowed_sample_statistics.sv
sv/wss_checker.sv
tb/wss_checker.sv
tb/tb_top.sv
